FILE: src/tbb_pkg.sv
package tbb_pkg;

   // field widths
   localparam int unsigned COORD_W = 32;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned ROW_W   = 3 * COEF_W;
   localparam int unsigned COEF_FRAC = 14;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = ROW_W;

   // offsets from center need one bit more than the half sum
   localparam int unsigned DELTA_W = COORD_W + 2;
   localparam int unsigned PROD_W  = DELTA_W + COEF_W;
   localparam int unsigned TERM_W  = PROD_W - COEF_FRAC;
   localparam int unsigned SUM_W   = TERM_W + 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ROW_W-1:0] row_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_X   = 3'd0,
      CSR_ROW_Y   = 3'd1,
      CSR_ROW_Z   = 3'd2,
      CSR_SHIFT_X = 3'd3,
      CSR_SHIFT_Y = 3'd4,
      CSR_SHIFT_Z = 3'd5
   } csr_index_type;

   // identity matrix at reset (1.0 in Q2.14 on the diagonal)
   localparam row_type ROW_X_RESET = 48'h0000_0000_4000;
   localparam row_type ROW_Y_RESET = 48'h0000_4000_0000;
   localparam row_type ROW_Z_RESET = 48'h4000_0000_0000;

   localparam coord_type COORD_MAX = 32'sh7fff_ffff;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

endpackage

FILE: src/transformed_box_bounds_top.sv
// Transformed box bounds: takes one axis-aligned box (min and max corners,
// signed Q16.16) and returns the axis-aligned bounds of that box after the
// configured 3x3 Q2.14 matrix is applied about the box center and the
// translation is added; results saturate to 32 bits. One box is accepted
// every clock cycle while the result side does not stall; its result passes
// the input register, then the result register. The 8 corners are not
// walked: since each axis offset enters the sum on its own, the bound is the
// sum of per-axis min/max of two products, so 18 parallel 34x16 multipliers
// in the single stage between the two registers set the clock. The matrix
// and translation are written through the csr port; the user must do so
// only while no box is in flight (not enforced); other indexes are ignored.
module transformed_box_bounds_top (
   input  logic clock,
   input  logic reset,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tbb_pkg::CSR_DATA_W-1:0]      csr_data,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  tbb_pkg::coord_type                  req_lo_x,
   input  tbb_pkg::coord_type                  req_lo_y,
   input  tbb_pkg::coord_type                  req_lo_z,
   input  tbb_pkg::coord_type                  req_hi_x,
   input  tbb_pkg::coord_type                  req_hi_y,
   input  tbb_pkg::coord_type                  req_hi_z,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tbb_pkg::coord_type                  rsp_new_lo_x,
   output tbb_pkg::coord_type                  rsp_new_lo_y,
   output tbb_pkg::coord_type                  rsp_new_lo_z,
   output tbb_pkg::coord_type                  rsp_new_hi_x,
   output tbb_pkg::coord_type                  rsp_new_hi_y,
   output tbb_pkg::coord_type                  rsp_new_hi_z
);

   localparam int unsigned DW = tbb_pkg::DELTA_W;
   localparam int unsigned PW = tbb_pkg::PROD_W;
   localparam int unsigned TW = tbb_pkg::TERM_W;
   localparam int unsigned SW = tbb_pkg::SUM_W;
   localparam int unsigned CW = tbb_pkg::COORD_W;
   localparam int unsigned KW = tbb_pkg::COEF_W;

   // configuration registers
   tbb_pkg::row_type   row_ff   [3];
   tbb_pkg::coord_type shift_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= tbb_pkg::ROW_X_RESET;
         row_ff[1]   <= tbb_pkg::ROW_Y_RESET;
         row_ff[2]   <= tbb_pkg::ROW_Z_RESET;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tbb_pkg::CSR_ROW_X:   row_ff[0]   <= csr_data;
            tbb_pkg::CSR_ROW_Y:   row_ff[1]   <= csr_data;
            tbb_pkg::CSR_ROW_Z:   row_ff[2]   <= csr_data;
            tbb_pkg::CSR_SHIFT_X: shift_ff[0] <= csr_data[CW-1:0];
            tbb_pkg::CSR_SHIFT_Y: shift_ff[1] <= csr_data[CW-1:0];
            tbb_pkg::CSR_SHIFT_Z: shift_ff[2] <= csr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   // handshake control
   logic in_valid_ff;
   logic out_valid_ff;
   logic advance;
   logic req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // input register
   tbb_pkg::coord_type lo_ff [3];
   tbb_pkg::coord_type hi_ff [3];

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         lo_ff[0] <= req_lo_x;
         lo_ff[1] <= req_lo_y;
         lo_ff[2] <= req_lo_z;
         hi_ff[0] <= req_hi_x;
         hi_ff[1] <= req_hi_y;
         hi_ff[2] <= req_hi_z;
      end
   end

   // center and offsets of the two corner values on each axis
   logic signed [CW:0]   half_sum [3];
   logic signed [CW:0]   ctr      [3];
   logic signed [DW-1:0] d_lo     [3];
   logic signed [DW-1:0] d_hi     [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         half_sum[a] = {lo_ff[a][CW-1], lo_ff[a]} + {hi_ff[a][CW-1], hi_ff[a]};
         ctr[a]      = half_sum[a] >>> 1;
         d_lo[a]     = DW'(lo_ff[a]) - DW'(ctr[a]);
         d_hi[a]     = DW'(hi_ff[a]) - DW'(ctr[a]);
      end
   end

   // per row and axis: floored products of both offsets, keep min and max
   logic signed [KW-1:0] coef     [3][3];
   logic signed [PW-1:0] prod_lo  [3][3];
   logic signed [PW-1:0] prod_hi  [3][3];
   logic signed [TW-1:0] term_lo  [3][3];
   logic signed [TW-1:0] term_hi  [3][3];
   logic signed [TW-1:0] term_min [3][3];
   logic signed [TW-1:0] term_max [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int a = 0; a < 3; a++) begin
            coef[r][a]    = row_ff[r][KW*a +: KW];
            prod_lo[r][a] = d_lo[a] * coef[r][a];
            prod_hi[r][a] = d_hi[a] * coef[r][a];
            term_lo[r][a] = prod_lo[r][a][PW-1:tbb_pkg::COEF_FRAC];
            term_hi[r][a] = prod_hi[r][a][PW-1:tbb_pkg::COEF_FRAC];
            if (term_lo[r][a] < term_hi[r][a]) begin
               term_min[r][a] = term_lo[r][a];
               term_max[r][a] = term_hi[r][a];
            end else begin
               term_min[r][a] = term_hi[r][a];
               term_max[r][a] = term_lo[r][a];
            end
         end
      end
   end

   // row sums, translation, center, then saturation
   logic signed [SW-1:0] base    [3];
   logic signed [SW-1:0] sum_min [3];
   logic signed [SW-1:0] sum_max [3];
   tbb_pkg::coord_type   new_lo_in [3];
   tbb_pkg::coord_type   new_hi_in [3];

   function automatic tbb_pkg::coord_type sat_coord(input logic signed [SW-1:0] v);
      tbb_pkg::coord_type res;
      if (v > SW'(tbb_pkg::COORD_MAX)) begin
         res = tbb_pkg::COORD_MAX;
      end else if (v < SW'(tbb_pkg::COORD_MIN)) begin
         res = tbb_pkg::COORD_MIN;
      end else begin
         res = v[CW-1:0];
      end
      return res;
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         base[r]    = SW'(shift_ff[r]) + SW'(ctr[r]);
         sum_min[r] = SW'(term_min[r][0]) + SW'(term_min[r][1])
                    + SW'(term_min[r][2]) + base[r];
         sum_max[r] = SW'(term_max[r][0]) + SW'(term_max[r][1])
                    + SW'(term_max[r][2]) + base[r];
         new_lo_in[r] = sat_coord(sum_min[r]);
         new_hi_in[r] = sat_coord(sum_max[r]);
      end
   end

   // result register
   tbb_pkg::coord_type new_lo_ff [3];
   tbb_pkg::coord_type new_hi_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         new_lo_ff <= new_lo_in;
         new_hi_ff <= new_hi_in;
      end
   end

   assign rsp_new_lo_x = new_lo_ff[0];
   assign rsp_new_lo_y = new_lo_ff[1];
   assign rsp_new_lo_z = new_lo_ff[2];
   assign rsp_new_hi_x = new_hi_ff[0];
   assign rsp_new_hi_y = new_hi_ff[1];
   assign rsp_new_hi_z = new_hi_ff[2];

   // checks
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_lo_x <= rsp_new_hi_x) && (rsp_new_lo_y <= rsp_new_hi_y)
                    && (rsp_new_lo_z <= rsp_new_hi_z))
      else $error("result bounds out of order");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted box not held in input register");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced box did not reach result register");

endmodule

FILE: sim/transformed_box_bounds_top_tb.sv
`timescale 1ns / 100ps

module transformed_box_bounds_top_tb;

   // box and bounds: entries 0..2 are the low x/y/z, entries 3..5 the high x/y/z
   typedef logic [5:0][tbb_pkg::COORD_W-1:0] box_type;
   typedef logic [5:0][tbb_pkg::COORD_W-1:0] bounds_type;

   localparam logic [tbb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [tbb_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTED = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [tbb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tbb_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   logic               req_valid = 1'b0;
   logic               req_ready;
   tbb_pkg::coord_type req_lo_x = '0;
   tbb_pkg::coord_type req_lo_y = '0;
   tbb_pkg::coord_type req_lo_z = '0;
   tbb_pkg::coord_type req_hi_x = '0;
   tbb_pkg::coord_type req_hi_y = '0;
   tbb_pkg::coord_type req_hi_z = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   tbb_pkg::coord_type rsp_new_lo_x;
   tbb_pkg::coord_type rsp_new_lo_y;
   tbb_pkg::coord_type rsp_new_lo_z;
   tbb_pkg::coord_type rsp_new_hi_x;
   tbb_pkg::coord_type rsp_new_hi_y;
   tbb_pkg::coord_type rsp_new_hi_z;

   // local copy of the transform registers
   logic [2:0][tbb_pkg::ROW_W-1:0]   xf_rows;
   logic [2:0][tbb_pkg::COORD_W-1:0] xf_shift;

   bounds_type expected_bounds[$];
   int mismatch_count = 0;
   int results_seen = 0;
   bit sender_idle_on = 1'b1;
   bit sink_idle_on = 1'b1;
   bit long_hold_ask = 1'b0;
   int stall_left = 0;
   int hold_left = 0;
   string field_name [6] = '{"new_lo_x", "new_lo_y", "new_lo_z",
                             "new_hi_x", "new_hi_y", "new_hi_z"};

   transformed_box_bounds_top uut (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_lo_x     (req_lo_x),
      .req_lo_y     (req_lo_y),
      .req_lo_z     (req_lo_z),
      .req_hi_x     (req_hi_x),
      .req_hi_y     (req_hi_y),
      .req_hi_z     (req_hi_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_new_lo_x (rsp_new_lo_x),
      .rsp_new_lo_y (rsp_new_lo_y),
      .rsp_new_lo_z (rsp_new_lo_z),
      .rsp_new_hi_x (rsp_new_hi_x),
      .rsp_new_hi_y (rsp_new_hi_y),
      .rsp_new_hi_z (rsp_new_hi_z)
   );

   always #5 clock = ~clock;

   // mismatch report, printing capped so a broken build stays readable
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at result %0d: %s", results_seen, msg);
   endtask

   function automatic logic [tbb_pkg::COORD_W-1:0] clamp_coord(input longint v);
      if (v > longint'(tbb_pkg::COORD_MAX)) return tbb_pkg::COORD_MAX;
      if (v < longint'(tbb_pkg::COORD_MIN)) return tbb_pkg::COORD_MIN;
      return v[tbb_pkg::COORD_W-1:0];
   endfunction

   // bounds of the 8 corners moved about the box center, exact in 64 bits
   function automatic bounds_type transform_bounds(input box_type b);
      longint lo[3], hi[3], mid[3], off[3], mn[3], mx[3];
      longint acc;
      shortint coef;
      bounds_type r;
      for (int a = 0; a < 3; a++) begin
         lo[a] = $signed(b[a]);
         hi[a] = $signed(b[a+3]);
         mid[a] = (lo[a] + hi[a]) >>> 1;
      end
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++)
            off[a] = ((((k >> a) & 1) != 0) ? hi[a] : lo[a]) - mid[a];
         for (int a = 0; a < 3; a++) begin
            acc = longint'($signed(xf_shift[a])) + mid[a];
            for (int c = 0; c < 3; c++) begin
               coef = xf_rows[a][c*tbb_pkg::COEF_W +: tbb_pkg::COEF_W];
               // floor of the Q2.14 product back to Q16.16
               acc += (off[c] * coef) >>> tbb_pkg::COEF_FRAC;
            end
            if (k == 0 || acc < mn[a]) mn[a] = acc;
            if (k == 0 || acc > mx[a]) mx[a] = acc;
         end
      end
      for (int a = 0; a < 3; a++) begin
         r[a] = clamp_coord(mn[a]);
         r[a+3] = clamp_coord(mx[a]);
      end
      return r;
   endfunction

   // one box transfer; valid stays high when the next box follows at once
   task automatic send_box(input box_type b);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lo_x <= b[0];
      req_lo_y <= b[1];
      req_lo_z <= b[2];
      req_hi_x <= b[3];
      req_hi_y <= b[4];
      req_hi_z <= b[5];
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_bounds.insert(expected_bounds.size(), transform_bounds(b));
   endtask

   // stop offering boxes and wait for every result
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_bounds.size() != 0) @(posedge clock);
   endtask

   // one register transfer; valid is left high for a following write
   task automatic write_csr(input logic [tbb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tbb_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         tbb_pkg::CSR_ROW_X:   xf_rows[0] = data;
         tbb_pkg::CSR_ROW_Y:   xf_rows[1] = data;
         tbb_pkg::CSR_ROW_Z:   xf_rows[2] = data;
         tbb_pkg::CSR_SHIFT_X: xf_shift[0] = data[tbb_pkg::COORD_W-1:0];
         tbb_pkg::CSR_SHIFT_Y: xf_shift[1] = data[tbb_pkg::COORD_W-1:0];
         tbb_pkg::CSR_SHIFT_Z: xf_shift[2] = data[tbb_pkg::COORD_W-1:0];
         default: ;
      endcase
   endtask

   // all six registers plus writes to the unused indexes, which must be ignored
   task automatic load_transform(input logic [2:0][tbb_pkg::ROW_W-1:0] rows,
                                 input logic [2:0][tbb_pkg::COORD_W-1:0] shifts);
      write_csr(tbb_pkg::CSR_ROW_X, rows[0]);
      write_csr(tbb_pkg::CSR_ROW_Y, rows[1]);
      write_csr(CSR_SPARE_A, {16'($urandom), 32'($urandom)});
      write_csr(tbb_pkg::CSR_ROW_Z, rows[2]);
      write_csr(tbb_pkg::CSR_SHIFT_X, {16'($urandom), shifts[0]});
      write_csr(tbb_pkg::CSR_SHIFT_Y, {16'($urandom), shifts[1]});
      write_csr(tbb_pkg::CSR_SHIFT_Z, {16'($urandom), shifts[2]});
      write_csr(CSR_SPARE_B, {16'($urandom), 32'($urandom)});
      csr_valid <= 1'b0;
   endtask

   function automatic box_type box_of(input logic [tbb_pkg::COORD_W-1:0] lx, ly, lz,
                                      input logic [tbb_pkg::COORD_W-1:0] hx, hy, hz);
      return {hz, hy, hx, lz, ly, lx};
   endfunction

   // corner cases: full range, inverted, points at the limits, odd half sums
   function automatic box_type edge_box(input int i);
      case (i)
         0: return box_of(0, 0, 0, 0, 0, 0);
         1: return box_of(tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN,
                          tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX);
         2: return box_of(tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX,
                          tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN);
         3: return box_of(tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX,
                          tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX);
         4: return box_of(tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN,
                          tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN);
         5: return box_of(-3, -1, 1, 0, 0, 2);
         6: return box_of('h10000, 0, 0, -'h10000, 'h10000, 'h10000);
         default: return box_of(-'h18000, -'h18000, -'h18000, 'h8000, 'h8000, 'h8000);
      endcase
   endfunction

   function automatic logic [tbb_pkg::COORD_W-1:0] rand_coord();
      logic [tbb_pkg::COORD_W-1:0] w;
      w = $urandom;
      case ($urandom_range(0, 4))
         0: return w;
         1: return $urandom_range(0, 'h1ffff) - 'h10000;
         2: return tbb_pkg::COORD_MAX - $urandom_range(0, 'hff);
         3: return tbb_pkg::COORD_MIN + $urandom_range(0, 'hff);
         default: return {{10{w[31]}}, w[31:10]};
      endcase
   endfunction

   // mostly ordered boxes, some tight, some inverted
   function automatic box_type rand_box();
      box_type b;
      logic [tbb_pkg::COORD_W-1:0] p, q;
      bit ordered;
      ordered = $urandom_range(0, 9) < 8;
      for (int a = 0; a < 3; a++) begin
         p = rand_coord();
         if ($urandom_range(0, 3) == 0) q = p + $urandom_range(0, 'hfffff);
         else q = rand_coord();
         if (ordered && $signed(p) > $signed(q)) begin
            b[a] = q;
            b[a+3] = p;
         end else begin
            b[a] = p;
            b[a+3] = q;
         end
      end
      return b;
   endfunction

   function automatic logic [tbb_pkg::COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: return 16'h8000;
         2: return 16'h7fff;
         3: return 16'h0000;
         default: return 16'($urandom_range(0, 'h8000) - 'h4000);
      endcase
   endfunction

   function automatic logic [tbb_pkg::COORD_W-1:0] rand_shift();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return tbb_pkg::COORD_MAX;
         2: return tbb_pkg::COORD_MIN;
         default: return $urandom_range(0, 'h3fffff) - 'h200000;
      endcase
   endfunction

   // result side: check each transfer, then pick the stall before the next
   always @(posedge clock) begin : result_sink
      bounds_type got, want;
      bit moved;
      moved = !reset && rsp_valid === 1'b1 && rsp_ready === 1'b1;
      if (moved) begin
         got = {rsp_new_hi_z, rsp_new_hi_y, rsp_new_hi_x,
                rsp_new_lo_z, rsp_new_lo_y, rsp_new_lo_x};
         if (expected_bounds.size() == 0) begin
            report_mismatch("result transfer with no box outstanding");
         end else begin
            want = expected_bounds.pop_front();
            for (int f = 0; f < 6; f++)
               if (got[f] !== want[f])
                  report_mismatch($sformatf("%s got %0d want %0d", field_name[f],
                                            $signed(got[f]), $signed(want[f])));
         end
         results_seen++;
         stall_left = sink_idle_on ? $urandom_range(0, 6) : 0;
      end
      // long hold-off so the block fills and stalls its input
      if (long_hold_ask) begin
         long_hold_ask = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // identity transform left by reset, over the corner cases
   task automatic test_reset_transform();
      for (int i = 0; i < 8; i++) send_box(edge_box(i));
      drain();
   endtask

   // saturating matrices and translations, and a zero matrix
   task automatic test_extreme_transforms();
      load_transform({3{{3{16'h8000}}}}, {3{tbb_pkg::COORD_MAX}});
      for (int i = 0; i < 4; i++) send_box(edge_box(i));
      drain();
      load_transform({3{{3{16'h7fff}}}}, {3{tbb_pkg::COORD_MIN}});
      for (int i = 1; i < 5; i++) send_box(edge_box(i));
      drain();
      load_transform('0, {tbb_pkg::COORD_MIN, 32'($urandom), tbb_pkg::COORD_MAX});
      send_box(edge_box(1));
      send_box(rand_box());
      drain();
   endtask

   // random transforms, each followed by a stream of random boxes
   task automatic test_random_transforms();
      logic [2:0][tbb_pkg::ROW_W-1:0] rows;
      logic [2:0][tbb_pkg::COORD_W-1:0] shifts;
      for (int p = 0; p < 5; p++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
               rows[r][c*tbb_pkg::COEF_W +: tbb_pkg::COEF_W] = rand_coef();
            shifts[r] = rand_shift();
         end
         load_transform(rows, shifts);
         repeat (160) send_box(rand_box());
         drain();
      end
   endtask

   // back-to-back boxes against a receiver that holds off for a long stretch
   task automatic test_input_stall();
      sender_idle_on = 1'b0;
      long_hold_ask = 1'b1;
      repeat (100) send_box(rand_box());
      drain();
      sender_idle_on = 1'b1;
   endtask

   // full rate on both sides
   task automatic test_full_rate();
      sender_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      repeat (120) send_box(rand_box());
      drain();
      sender_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   initial begin
      xf_rows = {tbb_pkg::ROW_Z_RESET, tbb_pkg::ROW_Y_RESET, tbb_pkg::ROW_X_RESET};
      xf_shift = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_transform();
      test_extreme_transforms();
      test_random_transforms();
      test_input_stall();
      test_full_rate();
      // let any stray result show up
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
